// ----- rtl/c_like_token_scanner_assert.svh -----
// assertion macros for the token scanner
`ifndef C_LIKE_TOKEN_SCANNER_ASSERT_SVH
`define C_LIKE_TOKEN_SCANNER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CLTS_ASSERT_IMP(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define CLTS_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- rtl/clts_pkg.sv -----
`default_nettype none
package clts_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;

    localparam int LEN_BITS = 16;
    localparam int ERR_BITS = 16;
    localparam int CLS_BITS = 6;

    // pending token kinds
    typedef enum logic [2:0] {
        PK_NONE    = 3'd0,
        PK_IDENT   = 3'd1,
        PK_NUMBER  = 3'd2,
        PK_EXCL    = 3'd3,
        PK_LESS    = 3'd4,
        PK_GREATER = 3'd5,
        PK_AMP     = 3'd6,
        PK_PIPE    = 3'd7
    } pkind_t;

    // token classes
    localparam logic [5:0] TC_END      = 6'd0;
    localparam logic [5:0] TC_IDENT    = 6'd1;
    localparam logic [5:0] TC_INT      = 6'd2;
    localparam logic [5:0] TC_BOOL_LIT = 6'd3;
    localparam logic [5:0] TC_IF       = 6'd4;
    localparam logic [5:0] TC_ELSE     = 6'd5;
    localparam logic [5:0] TC_WHILE    = 6'd6;
    localparam logic [5:0] TC_FOR      = 6'd7;
    localparam logic [5:0] TC_RETURN   = 6'd8;
    localparam logic [5:0] TC_BREAK    = 6'd9;
    localparam logic [5:0] TC_CONTINUE = 6'd10;
    localparam logic [5:0] TC_INT_KW   = 6'd11;
    localparam logic [5:0] TC_BOOL_KW  = 6'd12;
    localparam logic [5:0] TC_PLUS     = 6'd13;
    localparam logic [5:0] TC_MINUS    = 6'd14;
    localparam logic [5:0] TC_STAR     = 6'd15;
    localparam logic [5:0] TC_SLASH    = 6'd16;
    localparam logic [5:0] TC_PERCENT  = 6'd17;
    localparam logic [5:0] TC_NOT      = 6'd18;
    localparam logic [5:0] TC_NE       = 6'd19;
    localparam logic [5:0] TC_LT       = 6'd20;
    localparam logic [5:0] TC_SHL      = 6'd21;
    localparam logic [5:0] TC_LE       = 6'd22;
    localparam logic [5:0] TC_GT       = 6'd23;
    localparam logic [5:0] TC_SHR      = 6'd24;
    localparam logic [5:0] TC_GE       = 6'd25;
    localparam logic [5:0] TC_AND      = 6'd26;
    localparam logic [5:0] TC_LAND     = 6'd27;
    localparam logic [5:0] TC_OR       = 6'd28;
    localparam logic [5:0] TC_LOR      = 6'd29;
    localparam logic [5:0] TC_XOR      = 6'd30;
    localparam logic [5:0] TC_SEMI     = 6'd31;
    localparam logic [5:0] TC_COMMA    = 6'd32;
    localparam logic [5:0] TC_LPAREN   = 6'd33;
    localparam logic [5:0] TC_RPAREN   = 6'd34;
    localparam logic [5:0] TC_LBRACE   = 6'd35;
    localparam logic [5:0] TC_RBRACE   = 6'd36;
    localparam logic [5:0] TC_ASSIGN   = 6'd37;
    localparam logic [5:0] TC_ERROR    = 6'd38;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // class of a single-character operator or delimiter that never pairs, error otherwise
    function automatic logic [5:0] single_class(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            8'h2B:   r = TC_PLUS;
            8'h2D:   r = TC_MINUS;
            8'h2A:   r = TC_STAR;
            8'h2F:   r = TC_SLASH;
            8'h25:   r = TC_PERCENT;
            8'h5E:   r = TC_XOR;
            8'h3B:   r = TC_SEMI;
            8'h2C:   r = TC_COMMA;
            8'h28:   r = TC_LPAREN;
            8'h29:   r = TC_RPAREN;
            8'h7B:   r = TC_LBRACE;
            8'h7D:   r = TC_RBRACE;
            8'h3D:   r = TC_ASSIGN;
            default: r = TC_ERROR;
        endcase
        return r;
    endfunction

    // keyword lookup on the first 8 identifier bytes
    function automatic logic [5:0] ident_class(input logic [63:0] p,
                                               input logic [15:0] len);
        logic [5:0] r;
        r = TC_IDENT;
        if (len == 16'd2 && p[15:0] == 16'h6669) r = TC_IF;
        if (len == 16'd4 && p[31:0] == 32'h65736C65) r = TC_ELSE;
        if (len == 16'd5 && p[39:0] == 40'h656C696877) r = TC_WHILE;
        if (len == 16'd3 && p[23:0] == 24'h726F66) r = TC_FOR;
        if (len == 16'd6 && p[47:0] == 48'h6E7275746572) r = TC_RETURN;
        if (len == 16'd5 && p[39:0] == 40'h6B61657262) r = TC_BREAK;
        if (len == 16'd8 && p == 64'h65756E69746E6F63) r = TC_CONTINUE;
        if (len == 16'd3 && p[23:0] == 24'h746E69) r = TC_INT_KW;
        if (len == 16'd4 && p[31:0] == 32'h6C6F6F62) r = TC_BOOL_KW;
        if (len == 16'd4 && p[31:0] == 32'h65757274) r = TC_BOOL_LIT;
        if (len == 16'd5 && p[39:0] == 40'h65736C6166) r = TC_BOOL_LIT;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/clts_core.sv -----
`default_nettype none
// scanner state and decision logic; one character per cycle in while step is high, up to two tokens out
module clts_core #(
    parameter int OFFSET_BITS = clts_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = clts_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = clts_pkg::COLUMN_BITS_DEF,
    parameter int TOK_BITS    = 6 + OFFSET_BITS + LINE_BITS + COLUMN_BITS + 32
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          char_code,
    input  wire logic                end_of_text,
    output logic      [1:0]          tok_count,
    output logic      [TOK_BITS-1:0] tok0,
    output logic      [TOK_BITS-1:0] tok1
);
    import clts_pkg::*;

    pkind_t                   pkind_reg, pkind_next;
    logic [OFFSET_BITS-1:0]   poff_reg, poff_next;
    logic [LINE_BITS-1:0]     pline_reg, pline_next;
    logic [COLUMN_BITS-1:0]   pcol_reg, pcol_next;
    logic [LEN_BITS-1:0]      plen_reg, plen_next;
    logic [63:0]              prefix_reg, prefix_next;
    logic [OFFSET_BITS-1:0]   off_reg, off_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [COLUMN_BITS-1:0]   col_reg, col_next;
    logic [ERR_BITS-1:0]      err_reg, err_next;

    logic [5:0]  pair_cls;
    logic [5:0]  flush_cls;
    logic [5:0]  sc;
    logic        grow;
    logic [ERR_BITS-1:0] err_out;

    always_comb
    begin
        pair_cls = TC_END;
        grow = 1'b0;
        case (pkind_reg)
            PK_IDENT:   grow = is_letter(char_code) || is_digit(char_code)
                               || char_code == 8'h5F;
            PK_NUMBER:  grow = is_digit(char_code);
            PK_EXCL:    if (char_code == 8'h3D) pair_cls = TC_NE;
            PK_LESS:    if (char_code == 8'h3C) pair_cls = TC_SHL;
                        else if (char_code == 8'h3D) pair_cls = TC_LE;
            PK_GREATER: if (char_code == 8'h3E) pair_cls = TC_SHR;
                        else if (char_code == 8'h3D) pair_cls = TC_GE;
            PK_AMP:     if (char_code == 8'h26) pair_cls = TC_LAND;
            PK_PIPE:    if (char_code == 8'h7C) pair_cls = TC_LOR;
            default:    pair_cls = TC_END;
        endcase
        case (pkind_reg)
            PK_IDENT:   flush_cls = ident_class(prefix_reg, plen_reg);
            PK_NUMBER:  flush_cls = TC_INT;
            PK_EXCL:    flush_cls = TC_NOT;
            PK_LESS:    flush_cls = TC_LT;
            PK_GREATER: flush_cls = TC_GT;
            PK_AMP:     flush_cls = TC_AND;
            PK_PIPE:    flush_cls = TC_OR;
            default:    flush_cls = TC_END;
        endcase
    end

    assign sc = single_class(char_code);

    always_comb
    begin
        pkind_next  = pkind_reg;
        poff_next   = poff_reg;
        pline_next  = pline_reg;
        pcol_next   = pcol_reg;
        plen_next   = plen_reg;
        prefix_next = prefix_reg;
        off_next    = off_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        err_next    = err_reg;
        err_out     = err_reg;
        tok_count   = 2'd0;
        tok0 = {TOK_BITS{1'b0}};
        tok1 = {TOK_BITS{1'b0}};
        if (end_of_text)
        begin
            if (pkind_reg != PK_NONE)
            begin
                tok_count = 2'd2;
                tok0 = {err_reg, plen_reg, pcol_reg, pline_reg, poff_reg, flush_cls};
                tok1 = {err_reg, {LEN_BITS{1'b0}}, col_reg, line_reg, off_reg, TC_END};
            end
            else
            begin
                tok_count = 2'd1;
                tok0 = {err_reg, {LEN_BITS{1'b0}}, col_reg, line_reg, off_reg, TC_END};
            end
            pkind_next = PK_NONE;
        end
        else
        begin
            off_next = off_reg + 1'b1;
            if (char_code == 8'h0A)
            begin
                if (line_reg != {LINE_BITS{1'b1}}) line_next = line_reg + 1'b1;
                col_next = '0;
            end
            else if (col_reg != {COLUMN_BITS{1'b1}})
            begin
                col_next = col_reg + 1'b1;
            end
            if (grow)
            begin
                if (pkind_reg == PK_IDENT && plen_reg < 16'd8)
                    prefix_next = prefix_reg | ({56'd0, char_code} << {plen_reg[2:0], 3'b000});
                if (plen_reg != {LEN_BITS{1'b1}}) plen_next = plen_reg + 1'b1;
            end
            else if (pair_cls != TC_END)
            begin
                tok_count = 2'd1;
                tok0 = {err_reg, 16'd2, pcol_reg, pline_reg, poff_reg, pair_cls};
                plen_next = 16'd2;
                pkind_next = PK_NONE;
            end
            else
            begin
                pkind_next = PK_NONE;
                if (sc == TC_ERROR && err_reg != {ERR_BITS{1'b1}})
                    err_out = err_reg + 1'b1;
                if (char_code == 8'h20 || char_code == 8'h09 || char_code == 8'h0A)
                begin
                    pkind_next = PK_NONE;
                end
                else if (is_letter(char_code) || is_digit(char_code)
                         || char_code == 8'h21 || char_code == 8'h3C
                         || char_code == 8'h3E || char_code == 8'h26
                         || char_code == 8'h7C)
                begin
                    if (is_letter(char_code))      pkind_next = PK_IDENT;
                    else if (is_digit(char_code))  pkind_next = PK_NUMBER;
                    else if (char_code == 8'h21)   pkind_next = PK_EXCL;
                    else if (char_code == 8'h3C)   pkind_next = PK_LESS;
                    else if (char_code == 8'h3E)   pkind_next = PK_GREATER;
                    else if (char_code == 8'h26)   pkind_next = PK_AMP;
                    else                           pkind_next = PK_PIPE;
                    poff_next   = off_reg;
                    pline_next  = line_reg;
                    pcol_next   = col_reg;
                    plen_next   = 16'd1;
                    prefix_next = is_letter(char_code) ? {56'd0, char_code} : 64'd0;
                    err_out     = err_reg;
                end
                else
                begin
                    err_next = err_out;
                    if (pkind_reg != PK_NONE)
                    begin
                        tok_count = 2'd2;
                        tok0 = {err_reg, plen_reg, pcol_reg, pline_reg, poff_reg,
                                flush_cls};
                        tok1 = {err_out, 16'd1, col_reg, line_reg, off_reg, sc};
                    end
                    else
                    begin
                        tok_count = 2'd1;
                        tok0 = {err_out, 16'd1, col_reg, line_reg, off_reg, sc};
                    end
                end
                if (tok_count == 2'd0 && pkind_reg != PK_NONE)
                begin
                    tok_count = 2'd1;
                    tok0 = {err_reg, plen_reg, pcol_reg, pline_reg, poff_reg, flush_cls};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkind_reg  <= PK_NONE;
            poff_reg   <= '0;
            pline_reg  <= '0;
            pcol_reg   <= '0;
            plen_reg   <= '0;
            prefix_reg <= '0;
            off_reg    <= '0;
            line_reg   <= '0;
            col_reg    <= '0;
            err_reg    <= '0;
        end
        else if (step)
        begin
            pkind_reg  <= pkind_next;
            poff_reg   <= poff_next;
            pline_reg  <= pline_next;
            pcol_reg   <= pcol_next;
            plen_reg   <= plen_next;
            prefix_reg <= prefix_next;
            off_reg    <= off_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            err_reg    <= err_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/clts_outq.sv -----
`default_nettype none
// result queue: up to two tokens from one beat, drained one per beat
module clts_outq #(
    parameter int TOK_BITS = 102
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic [1:0]          push_count,
    input  wire logic [TOK_BITS-1:0] push0,
    input  wire logic [TOK_BITS-1:0] push1,
    output logic                     can_push,
    output logic                     out_valid,
    output logic      [TOK_BITS-1:0] out_tok,
    output logic                     out_last,
    input  wire logic                out_ready
);
    // four slots, so two tokens can be taken while up to two wait
    logic [TOK_BITS-1:0] slot_reg [4];
    logic [3:0]          last_reg;
    logic [1:0]          rd_reg, rd_next, wr_reg, wr_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                pop;
    logic [2:0]          added;

    assign out_valid = cnt_reg != 3'd0;
    assign out_tok   = slot_reg[rd_reg];
    assign out_last  = last_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign can_push  = cnt_reg <= 3'd2;
    assign added     = push ? {1'b0, push_count} : 3'd0;
    assign rd_next   = rd_reg + {1'b0, pop};
    assign wr_next   = wr_reg + added[1:0];
    assign cnt_next  = cnt_reg + added - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push && push_count != 2'd0)
        begin
            slot_reg[wr_reg] <= push0;
            last_reg[wr_reg] <= push_count == 2'd1;
        end
        if (push && push_count == 2'd2)
        begin
            slot_reg[wr_reg + 2'd1] <= push1;
            last_reg[wr_reg + 2'd1] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/c_like_token_scanner.sv -----
`default_nettype none
// Longest-match scanner for a small C-like language. Each input beat carries
// one source byte (or the end marker in tuser); tokens leave on the master
// side once their extent is known, each with its start offset, line and
// column, its length and the running error count, and tlast marks the final
// token caused by one input beat. One byte is taken every cycle that s_tready
// is high: the scanner state is updated by a single pass of logic per beat,
// and results go into a four-entry queue, so s_tready only drops when that
// queue holds three or more untaken tokens. Results are written to the queue
// as their beat is taken; a beat yields at most two tokens, so a sink that
// takes one token per cycle keeps up except where two-token beats pile up.
module c_like_token_scanner #(
    parameter int OFFSET_BITS = clts_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = clts_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = clts_pkg::COLUMN_BITS_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic [7:0] s_tdata,   // char_code
    input  wire logic       s_tuser,   // end_of_text
    output logic      m_tvalid,
    input  wire logic m_tready,
    // token_class, start_offset, start_line, token column, lexeme_length,
    // errors_so_far, zero fill to whole bytes
    output logic [((6 + OFFSET_BITS + LINE_BITS + COLUMN_BITS + 32 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic      m_tlast      // last_of_run
);
    localparam int TOK_BITS = 6 + OFFSET_BITS + LINE_BITS + COLUMN_BITS + 32;
    localparam int OUT_BITS = ((TOK_BITS + 7) / 8) * 8;

    logic                step;
    logic [1:0]          tok_count;
    logic [TOK_BITS-1:0] tok0, tok1, q_tok;
    logic                can_push;

    assign s_tready = can_push;
    assign step     = s_tvalid && s_tready;

    clts_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .TOK_BITS    (TOK_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .char_code   (s_tdata),
        .end_of_text (s_tuser),
        .tok_count   (tok_count),
        .tok0        (tok0),
        .tok1        (tok1)
    );

    clts_outq #(
        .TOK_BITS (TOK_BITS)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_count (tok_count),
        .push0      (tok0),
        .push1      (tok1),
        .can_push   (can_push),
        .out_valid  (m_tvalid),
        .out_tok    (q_tok),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

    assign m_tdata = {{(OUT_BITS - TOK_BITS){1'b0}}, q_tok};

`include "c_like_token_scanner_assert.svh"

    // an end marker always yields output on the next cycle
    `CLTS_ASSERT_NEXT(a_end_gives_token, step && s_tuser, m_tvalid, "end marker lost")
    // the end marker always yields at least one token
    `CLTS_ASSERT_IMP(a_end_count, step && s_tuser, tok_count != 2'd0, "no token at end")
    // never accept while the queue cannot take two tokens
    `CLTS_ASSERT_IMP(a_no_overrun, step, can_push, "queue overrun")

endmodule
`default_nettype wire

// ----- test/c_like_token_scanner_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module c_like_token_scanner_tb;
    import clts_pkg::*;

    localparam int OFF_W  = 32;
    localparam int LINE_W = 16;
    localparam int COL_W  = 16;
    localparam int TD_W   = ((6 + OFF_W + LINE_W + COL_W + 32 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 700;

    // character codes used by the stimulus
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // one token as it leaves the scanner
    typedef struct packed {
        logic [5:0]        tclass;
        logic [OFF_W-1:0]  offset;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [15:0]       length;
        logic [15:0]       errors;
        logic              last;
    } token_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;    // char_code
    logic s_tuser;          // end_of_text
    logic m_tvalid;
    logic m_tready;
    logic [TD_W-1:0] m_tdata;   // class, offset, line, column, length, errors
    logic m_tlast;              // last_of_run

    c_like_token_scanner u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // scanner shadow state
    pkind_t            sh_kind;
    logic [OFF_W-1:0]  sh_start_off;
    logic [LINE_W-1:0] sh_start_line;
    logic [COL_W-1:0]  sh_start_col;
    logic [15:0]       sh_len;
    logic [63:0]       sh_prefix;
    logic [OFF_W-1:0]  sh_off;
    logic [LINE_W-1:0] sh_line;
    logic [COL_W-1:0]  sh_col;
    logic [15:0]       sh_errs;

    token_t expected_tokens[$];
    int     failures;

    function automatic bit letter_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // keyword recognition over the first eight identifier bytes
    function automatic logic [5:0] word_class(logic [63:0] p, logic [15:0] n);
        case (n)
            16'd2: if (p[15:0] == "fi") return TC_IF;
            16'd3:
            begin
                if (p[23:0] == "rof") return TC_FOR;
                if (p[23:0] == "tni") return TC_INT_KW;
            end
            16'd4:
            begin
                if (p[31:0] == "esle") return TC_ELSE;
                if (p[31:0] == "loob") return TC_BOOL_KW;
                if (p[31:0] == "eurt") return TC_BOOL_LIT;
            end
            16'd5:
            begin
                if (p[39:0] == "elihw") return TC_WHILE;
                if (p[39:0] == "kaerb") return TC_BREAK;
                if (p[39:0] == "eslaf") return TC_BOOL_LIT;
            end
            16'd6: if (p[47:0] == "nruter") return TC_RETURN;
            16'd8: if (p == "eunitnoc") return TC_CONTINUE;
            default: ;
        endcase
        return TC_IDENT;
    endfunction

    function automatic token_t make_tok(logic [5:0] cl, logic [OFF_W-1:0] o,
                                        logic [LINE_W-1:0] l, logic [COL_W-1:0] c,
                                        logic [15:0] n);
        token_t t;
        t.tclass = cl;
        t.offset = o;
        t.line   = l;
        t.column = c;
        t.length = n;
        t.errors = sh_errs;
        t.last   = 1'b0;
        return t;
    endfunction

    // emit the held token, if any
    task automatic flush_held(ref token_t q[$]);
        logic [5:0] cl;
        cl = TC_IDENT;
        case (sh_kind)
            PK_IDENT:   cl = word_class(sh_prefix, sh_len);
            PK_NUMBER:  cl = TC_INT;
            PK_EXCL:    cl = TC_NOT;
            PK_LESS:    cl = TC_LT;
            PK_GREATER: cl = TC_GT;
            PK_AMP:     cl = TC_AND;
            PK_PIPE:    cl = TC_OR;
            default:    ;
        endcase
        if (sh_kind != PK_NONE)
            q.push_back(make_tok(cl, sh_start_off, sh_start_line, sh_start_col, sh_len));
        sh_kind = PK_NONE;
    endtask

    task automatic advance_pos(logic [7:0] c);
        sh_off = sh_off + 1'b1;
        if (c == CH_NL)
        begin
            if (sh_line != '1) sh_line = sh_line + 1'b1;
            sh_col = '0;
        end
        else if (sh_col != '1)
            sh_col = sh_col + 1'b1;
    endtask

    task automatic hold_token(pkind_t k, logic [7:0] c);
        sh_kind       = k;
        sh_start_off  = sh_off;
        sh_start_line = sh_line;
        sh_start_col  = sh_col;
        sh_len        = 16'd1;
        sh_prefix     = (k == PK_IDENT) ? {56'd0, c} : 64'd0;
    endtask

    // tokens caused by one accepted input beat
    task automatic scan_beat(logic [7:0] c, logic eot, ref token_t q[$]);
        logic [5:0] pair;
        logic [5:0] cl;
        q = {};
        pair = '0;
        if (eot)
        begin
            flush_held(q);
            q.push_back(make_tok(TC_END, sh_off, sh_line, sh_col, 16'd0));
            q[$].last = 1'b1;
            return;
        end
        case (sh_kind)
            PK_IDENT, PK_NUMBER:
                if (digit_ch(c) || (sh_kind == PK_IDENT && (letter_ch(c) || c == CH_UNDER)))
                begin
                    if (sh_kind == PK_IDENT && sh_len < 16'd8)
                        sh_prefix = sh_prefix | ({56'd0, c} << (8 * sh_len));
                    if (sh_len != 16'hFFFF) sh_len = sh_len + 1'b1;
                    advance_pos(c);
                    return;
                end
            PK_EXCL:    if (c == "=") pair = TC_NE;
            PK_LESS:    if (c == "<") pair = TC_SHL; else if (c == "=") pair = TC_LE;
            PK_GREATER: if (c == ">") pair = TC_SHR; else if (c == "=") pair = TC_GE;
            PK_AMP:     if (c == "&") pair = TC_LAND;
            PK_PIPE:    if (c == "|") pair = TC_LOR;
            default:    ;
        endcase
        if (pair != '0)
        begin
            q.push_back(make_tok(pair, sh_start_off, sh_start_line, sh_start_col, 16'd2));
            sh_kind = PK_NONE;
        end
        else
        begin
            flush_held(q);
            if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
                ;
            else if (letter_ch(c)) hold_token(PK_IDENT, c);
            else if (digit_ch(c))  hold_token(PK_NUMBER, c);
            else if (c == "!")     hold_token(PK_EXCL, c);
            else if (c == "<")     hold_token(PK_LESS, c);
            else if (c == ">")     hold_token(PK_GREATER, c);
            else if (c == "&")     hold_token(PK_AMP, c);
            else if (c == "|")     hold_token(PK_PIPE, c);
            else
            begin
                case (c)
                    "+": cl = TC_PLUS;
                    "-": cl = TC_MINUS;
                    "*": cl = TC_STAR;
                    "/": cl = TC_SLASH;
                    "%": cl = TC_PERCENT;
                    "^": cl = TC_XOR;
                    ";": cl = TC_SEMI;
                    ",": cl = TC_COMMA;
                    "(": cl = TC_LPAREN;
                    ")": cl = TC_RPAREN;
                    "{": cl = TC_LBRACE;
                    "}": cl = TC_RBRACE;
                    "=": cl = TC_ASSIGN;
                    default: cl = TC_ERROR;
                endcase
                if (cl == TC_ERROR && sh_errs != 16'hFFFF) sh_errs = sh_errs + 1'b1;
                q.push_back(make_tok(cl, sh_off, sh_line, sh_col, 16'd1));
            end
        end
        advance_pos(c);
        if (q.size() > 0) q[$].last = 1'b1;
    endtask

    // input beats: {char, eot, typed flag, typed class or 0 when none}
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         typed;
        logic [5:0] cls;
    } beat_t;

    beat_t stim[$];

    task automatic add_text(string s);
        beat_t b;
        for (int i = 0; i < s.len(); i++)
        begin
            b.ch = s[i]; b.eot = 1'b0; b.typed = 1'b0; b.cls = '0;
            stim.push_back(b);
        end
    endtask

    task automatic add_beat(logic [7:0] c, logic e, bit t, logic [5:0] cl);
        beat_t b;
        b.ch = c; b.eot = e; b.typed = t; b.cls = cl;
        stim.push_back(b);
    endtask

    // random well-formed fragments with noise
    task automatic add_random_text(int count);
        string words[$];
        int base;
        words = {"if", "else", "while", "for", "return", "break", "continue", "int",
                 "bool", "true", "false", "x", "foo_1", "continuex", "Abc9", "42",
                 "007", "!=", "<<", "<=", ">>", ">=", "&&", "||", "!", "<", ">", "&",
                 "|", "+", "-", "*", "/", "%", "^", ";", ",", "(", ")", "{", "}", "=",
                 " ", "\t", "\n", "  "};
        base = stim.size();
        while (stim.size() - base < count)
        begin
            case ($urandom_range(9))
                0: add_beat(8'($urandom_range(255)), 1'b0, 1'b0, '0);
                1: add_beat(8'($urandom_range(255)), 1'b1, 1'b0, '0);
                2: begin
                    for (int i = $urandom_range(12, 1); i > 0; i--)
                        add_beat(($urandom_range(5) != 0) ? 8'(8'h61 + $urandom_range(25))
                                 : CH_UNDER, 1'b0, 1'b0, '0);
                end
                default: begin
                    add_text(words[$urandom_range(words.size() - 1)]);
                    if ($urandom_range(1)) add_beat(CH_SPACE, 1'b0, 1'b0, '0);
                end
            endcase
        end
        add_beat(8'h00, 1'b1, 1'b0, '0);
    endtask

    token_t step_q[$];
    int     cycles;

    // sink: random stall pattern, compares every accepted token
    always @(posedge clk)
    begin
        token_t got, want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(7) < 5) || (cycles % 200 < 40);
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[5:0], m_tdata[6 +: OFF_W], m_tdata[6 + OFF_W +: LINE_W],
                        m_tdata[6 + OFF_W + LINE_W +: COL_W],
                        m_tdata[6 + OFF_W + LINE_W + COL_W +: 16],
                        m_tdata[22 + OFF_W + LINE_W + COL_W +: 16], m_tlast};
                if (expected_tokens.size() == 0)
                begin
                    $error("token with nothing expected: class %0d", got.tclass);
                    failures++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got.tclass !== want.tclass)
                    begin
                        $error("token_class exp %0d got %0d", want.tclass, got.tclass);
                        failures++;
                    end
                    if (got.offset !== want.offset)
                    begin
                        $error("start_offset exp %0d got %0d", want.offset, got.offset);
                        failures++;
                    end
                    if (got.line !== want.line)
                    begin
                        $error("start_line exp %0d got %0d", want.line, got.line);
                        failures++;
                    end
                    if (got.column !== want.column)
                    begin
                        $error("token column exp %0d got %0d", want.column, got.column);
                        failures++;
                    end
                    if (got.length !== want.length)
                    begin
                        $error("lexeme_length exp %0d got %0d", want.length, got.length);
                        failures++;
                    end
                    if (got.errors !== want.errors)
                    begin
                        $error("errors_so_far exp %0d got %0d", want.errors, got.errors);
                        failures++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_of_run exp %0d got %0d", want.last, got.last);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("c_like_token_scanner_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int burst;
        beat_t b;
        failures = 0;
        cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        sh_kind = PK_NONE;
        {sh_start_off, sh_start_line, sh_start_col, sh_len, sh_prefix} = '0;
        {sh_off, sh_line, sh_col, sh_errs} = '0;

        // directed table: end right after reset, error bytes, a selection of operators
        add_beat(8'h00, 1'b1, 1'b1, TC_END);
        add_beat(8'hFF, 1'b0, 1'b1, TC_ERROR);
        add_beat(8'h80, 1'b0, 1'b1, TC_ERROR);
        add_beat(CH_CR, 1'b0, 1'b1, TC_ERROR);
        add_beat(CH_UNDER, 1'b0, 1'b1, TC_ERROR);
        add_beat(8'h00, 1'b0, 1'b1, TC_ERROR);
        add_beat(8'h7F, 1'b0, 1'b1, TC_ERROR);
        add_text("continue1 if<<=>>= != &&|| ! &|^x9\t\n");
        add_text("while(true){return 0;}");
        add_beat(8'hFF, 1'b1, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_random_text(RANDOM_BEATS);

        while (stim.size() > 0)
        begin
            burst = $urandom_range(20, 1);
            while (burst > 0 && stim.size() > 0)
            begin
                b = stim.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b.ch;
                s_tuser  <= b.eot;
                @(posedge clk);
                while (!s_tready) @(posedge clk);
                scan_beat(b.ch, b.eot, step_q);
                if (b.typed && (step_q.size() == 0 || step_q[0].tclass != b.cls))
                begin
                    $error("token_class exp %0d from table", b.cls);
                    failures++;
                end
                foreach (step_q[i]) expected_tokens.push_back(step_q[i]);
                burst--;
            end
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end

        while (expected_tokens.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("c_like_token_scanner_tb OK");
        else
            $display("c_like_token_scanner_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
